[rtl/gcd_pkg.sv]
`timescale 1ns / 1ps

package gcd_pkg;

  // trig word: Q30 with headroom for cordic growth and angles up to pi
  localparam int TrigW = 33;
  // radicand and root word of the square root cells
  localparam int SqW = 62;
  localparam int SqSteps = 31;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic [SqW-1:0] sq_t;

  // one cordic cell payload
  typedef struct packed {
    trig_t x;
    trig_t y;
    trig_t z;
    logic  flag;
  } cordic_t;

  // one square root cell payload, dot product travels alongside
  typedef struct packed {
    sq_t   n;
    sq_t   r;
    trig_t d;
  } sqrt_t;

  localparam trig_t Q30One = 33'sd1073741824;
  localparam trig_t InvGain = 33'sd652032874;
  localparam logic signed [34:0] PiQ30 = 35'sd3373259426;
  localparam logic [24:0] DegToRad = 25'd18740330;
  localparam logic [23:0] RadiusReset = 24'd6378137;
  localparam int DistW = 26;
  localparam int RadiusW = 24;

  function automatic trig_t atan_q30(int i);
    trig_t a;
    a = '0;
    case (i)
      0: a = 33'sd843314856;
      1: a = 33'sd497837829;
      2: a = 33'sd263043836;
      3: a = 33'sd133525158;
      4: a = 33'sd67021686;
      5: a = 33'sd33543515;
      6: a = 33'sd16775850;
      7: a = 33'sd8388437;
      8: a = 33'sd4194282;
      9: a = 33'sd2097149;
      default: begin
        if (i <= 30) a = trig_t'(64'd1 << (30 - i));
        else a = '0;
      end
    endcase
    return a;
  endfunction

endpackage

[rtl/gcd_angle_prep.sv]
`timescale 1ns / 1ps

module gcd_angle_prep #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int IN_W = 29
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [IN_W-1:0] angle_i,
  output gcd_pkg::trig_t         z_o,
  output logic                   neg_cos_o
);

  localparam longint unsigned Full = 64'd360 << ANGLE_FRAC_BITS;
  localparam longint unsigned Half = 64'd180 << ANGLE_FRAC_BITS;
  localparam longint unsigned Quarter = 64'd90 << ANGLE_FRAC_BITS;
  localparam longint unsigned Recip = ((64'd1 << 32) + Full - 64'd1) / Full;
  localparam int PrW = IN_W + 18;
  localparam int QW = IN_W - 14;
  localparam int PW = 50;
  localparam int RW = ANGLE_FRAC_BITS + 9;
  localparam int SW = ANGLE_FRAC_BITS + 10;
  localparam int MW = ANGLE_FRAC_BITS + 7;
  localparam int DW = MW + 25;

  localparam logic signed [17:0] RecipS = 18'(Recip);
  localparam logic signed [34:0] FullS = 35'(Full);
  localparam logic signed [PW-1:0] FullP = PW'(Full);
  localparam logic signed [SW-1:0] FullW = SW'(Full);
  localparam logic signed [SW-1:0] HalfW = SW'(Half);
  localparam logic signed [SW-1:0] QuarterW = SW'(Quarter);
  localparam logic [DW-1:0] RoundC = DW'(1) << (ANGLE_FRAC_BITS - 1);

  logic signed [IN_W-1:0] d1_q, d2_q;
  logic signed [PrW-1:0]  prod1_q;
  logic signed [QW-1:0]   quot;
  logic signed [PW-1:0]   p2_q, rem_raw, rem_fix;
  logic [RW-1:0]          r3_q;
  logic signed [SW-1:0]   sgn, fold, fold_abs;
  logic [MW-1:0]          mag4_q;
  logic                   neg_a4_q, neg_c4_q, neg_a5_q, neg_c5_q, neg_c6_q;
  logic                   fold_negc;
  logic [DW-1:0]          p5_q, p5_rnd;
  gcd_pkg::trig_t         z_mag, z6_q;

  // quotient estimate by reciprocal, off by at most one turn
  always_comb begin
    quot = prod1_q[PrW-1:32];
    rem_raw = PW'(d2_q) - p2_q;
    if (rem_raw < 0) rem_fix = rem_raw + FullP;
    else if (rem_raw >= FullP) rem_fix = rem_raw - FullP;
    else rem_fix = rem_raw;
  end

  // to [-180,180) and folded into [-90,90]
  always_comb begin
    sgn = $signed({1'b0, r3_q});
    if (sgn >= HalfW) sgn = sgn - FullW;
    fold_negc = 1'b0;
    if (sgn > QuarterW) begin
      fold = HalfW - sgn;
      fold_negc = 1'b1;
    end else if (sgn < -QuarterW) begin
      fold = -HalfW - sgn;
      fold_negc = 1'b1;
    end else begin
      fold = sgn;
    end
    fold_abs = fold[SW-1] ? -fold : fold;
  end

  always_comb begin
    p5_rnd = (p5_q + RoundC) >> ANGLE_FRAC_BITS;
    z_mag = gcd_pkg::trig_t'(p5_rnd);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q     <= angle_i;
      prod1_q  <= PrW'(angle_i) * PrW'(RecipS);
      d2_q     <= d1_q;
      p2_q     <= PW'(quot * FullS);
      r3_q     <= rem_fix[RW-1:0];
      mag4_q   <= fold_abs[MW-1:0];
      neg_a4_q <= fold[SW-1];
      neg_c4_q <= fold_negc;
      p5_q     <= DW'(mag4_q) * DW'(gcd_pkg::DegToRad);
      neg_a5_q <= neg_a4_q;
      neg_c5_q <= neg_c4_q;
      z6_q     <= neg_a5_q ? -z_mag : z_mag;
      neg_c6_q <= neg_c5_q;
    end
  end

  assign z_o = z6_q;
  assign neg_cos_o = neg_c6_q;

endmodule

[rtl/gcd_cordic_cell.sv]
`timescale 1ns / 1ps

module gcd_cordic_cell #(
  parameter int STAGE = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  gcd_pkg::cordic_t cell_i,
  output gcd_pkg::cordic_t cell_o
);

  localparam gcd_pkg::trig_t Atan = gcd_pkg::atan_q30(STAGE);

  gcd_pkg::trig_t   xs, ys;
  logic             neg;
  gcd_pkg::cordic_t cell_d, cell_q;

  always_comb begin
    xs = cell_i.x >>> STAGE;
    ys = cell_i.y >>> STAGE;
    // rotation steers on z, vectoring drives y toward zero
    neg = VECTORING ? !cell_i.y[gcd_pkg::TrigW-1] : cell_i.z[gcd_pkg::TrigW-1];
    cell_d.flag = cell_i.flag;
    if (neg) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + Atan;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - Atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

[rtl/gcd_isqrt_cell.sv]
`timescale 1ns / 1ps

module gcd_isqrt_cell #(
  parameter int STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  gcd_pkg::sqrt_t cell_i,
  output gcd_pkg::sqrt_t cell_o
);

  localparam gcd_pkg::sq_t Bit = gcd_pkg::sq_t'(1) << (2 * (gcd_pkg::SqSteps - 1 - STEP));

  gcd_pkg::sq_t   trial;
  gcd_pkg::sqrt_t cell_d, cell_q;

  always_comb begin
    trial = cell_i.r + Bit;
    cell_d.d = cell_i.d;
    if (cell_i.n >= trial) begin
      cell_d.n = cell_i.n - trial;
      cell_d.r = (cell_i.r >> 1) + Bit;
    end else begin
      cell_d.n = cell_i.n;
      cell_d.r = cell_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

[rtl/great_circle_distance_top.sv]
`timescale 1ns / 1ps

// channel | valid      | stall      | payload
// in      | in_valid_i | in_stall_o | lon_a_i, lat_a_i, lon_b_i, lat_b_i
// out     | out_valid_o| out_stall_i| distance_m_o
// config  | cfg_we_i   | -          | cfg_wdata_i (sphere radius, meters)
//
// one point pair enters per cycle unless out_stall_i holds a result; the pipeline is:
// 6 angle prep stages, TRIG_STEPS rotation cells, 5 product and dot stages,
// 31 square root cells, TRIG_STEPS vectoring cells and 3 output stages
// reset clears the valid pipeline and loads the radius; no clearing pass
// a stalled result freezes the whole pipeline, the output register holds it

module great_circle_distance_top #(
  parameter int ANGLE_FRAC_BITS = 20,
  parameter int TRIG_STEPS = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [28:0] lon_a_i,
  input  logic signed [27:0] lat_a_i,
  input  logic signed [28:0] lon_b_i,
  input  logic signed [27:0] lat_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [25:0]        distance_m_o,
  input  logic               cfg_we_i,
  input  logic [23:0]        cfg_wdata_i
);

  localparam int Lat = 45 + 2 * TRIG_STEPS;
  localparam int TW = gcd_pkg::TrigW;

  logic             adv;
  logic [Lat-1:0]   vld_q;
  logic [gcd_pkg::RadiusW-1:0] radius_q;

  gcd_pkg::trig_t   prep_z [4];
  logic             prep_negc [4];
  gcd_pkg::cordic_t rot_w [4][TRIG_STEPS+1];
  gcd_pkg::sqrt_t   sq_w [gcd_pkg::SqSteps+1];
  gcd_pkg::cordic_t acs_w [TRIG_STEPS+1];

  logic signed [2*TW-1:0] pa0_q, pa2_q, pb0_q, pb2_q;
  logic                   na0_q, na2_q, nb0_q, nb2_q;
  gcd_pkg::trig_t         sla_q, slb_q;
  logic signed [2*TW-1:0] pa0_s, pa2_s, pb0_s, pb2_s;
  gcd_pkg::trig_t         a0_q, a1_q, a2_q, b0_q, b1_q, b2_q;
  logic signed [2*TW-1:0] m0_q, m1_q, m2_q;
  logic signed [2*TW+1:0] dot_sum, dot_shr;
  gcd_pkg::trig_t         dot_c, dot4_q, dot5_q;
  logic [31:0]            one_m, one_p;
  logic [63:0]            rad_q;
  gcd_pkg::trig_t         d_fin, d_abs;
  logic signed [34:0]     ang_raw;
  logic [31:0]            ang_q;
  logic [55:0]            prod_q, prod_rnd;
  logic [gcd_pkg::DistW-1:0] dist_q;

  assign adv = !vld_q[Lat-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcd_pkg::RadiusReset;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  // angle order: lon_a, lat_a, lon_b, lat_b
  gcd_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(29)) u_prep_lon_a (
    .clk_i, .en_i(adv), .angle_i(lon_a_i), .z_o(prep_z[0]), .neg_cos_o(prep_negc[0])
  );
  gcd_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(28)) u_prep_lat_a (
    .clk_i, .en_i(adv), .angle_i(lat_a_i), .z_o(prep_z[1]), .neg_cos_o(prep_negc[1])
  );
  gcd_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(29)) u_prep_lon_b (
    .clk_i, .en_i(adv), .angle_i(lon_b_i), .z_o(prep_z[2]), .neg_cos_o(prep_negc[2])
  );
  gcd_angle_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .IN_W(28)) u_prep_lat_b (
    .clk_i, .en_i(adv), .angle_i(lat_b_i), .z_o(prep_z[3]), .neg_cos_o(prep_negc[3])
  );

  for (genvar c = 0; c < 4; c++) begin : g_rot
    assign rot_w[c][0].x = gcd_pkg::InvGain;
    assign rot_w[c][0].y = '0;
    assign rot_w[c][0].z = prep_z[c];
    assign rot_w[c][0].flag = prep_negc[c];
    for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cell
      gcd_cordic_cell #(.STAGE(i), .VECTORING(1'b0)) u_cell (
        .clk_i, .en_i(adv), .cell_i(rot_w[c][i]), .cell_o(rot_w[c][i+1])
      );
    end
  end

  // products are negated afterwards where the folded cosine flips sign
  always_comb begin
    pa0_s = na0_q ? -pa0_q : pa0_q;
    pa2_s = na2_q ? -pa2_q : pa2_q;
    pb0_s = nb0_q ? -pb0_q : pb0_q;
    pb2_s = nb2_q ? -pb2_q : pb2_q;
    dot_sum = (2*TW+2)'(m0_q) + (2*TW+2)'(m1_q) + (2*TW+2)'(m2_q);
    dot_shr = dot_sum >>> 30;
    if (dot_shr > (2*TW+2)'(gcd_pkg::Q30One)) dot_c = gcd_pkg::Q30One;
    else if (dot_shr < -(2*TW+2)'(gcd_pkg::Q30One)) dot_c = -gcd_pkg::Q30One;
    else dot_c = dot_shr[TW-1:0];
    one_m = 32'(gcd_pkg::Q30One - dot4_q);
    one_p = 32'(gcd_pkg::Q30One + dot4_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa0_q  <= rot_w[1][TRIG_STEPS].x * rot_w[0][TRIG_STEPS].y;
      na0_q  <= rot_w[1][TRIG_STEPS].flag;
      pa2_q  <= rot_w[1][TRIG_STEPS].x * rot_w[0][TRIG_STEPS].x;
      na2_q  <= rot_w[1][TRIG_STEPS].flag ^ rot_w[0][TRIG_STEPS].flag;
      sla_q  <= rot_w[1][TRIG_STEPS].y;
      pb0_q  <= rot_w[3][TRIG_STEPS].x * rot_w[2][TRIG_STEPS].y;
      nb0_q  <= rot_w[3][TRIG_STEPS].flag;
      pb2_q  <= rot_w[3][TRIG_STEPS].x * rot_w[2][TRIG_STEPS].x;
      nb2_q  <= rot_w[3][TRIG_STEPS].flag ^ rot_w[2][TRIG_STEPS].flag;
      slb_q  <= rot_w[3][TRIG_STEPS].y;
      a0_q   <= TW'(pa0_s >>> 30);
      a1_q   <= -sla_q;
      a2_q   <= TW'(pa2_s >>> 30);
      b0_q   <= TW'(pb0_s >>> 30);
      b1_q   <= -slb_q;
      b2_q   <= TW'(pb2_s >>> 30);
      m0_q   <= a0_q * b0_q;
      m1_q   <= a1_q * b1_q;
      m2_q   <= a2_q * b2_q;
      dot4_q <= dot_c;
      rad_q  <= 64'(one_m) * 64'(one_p);
      dot5_q <= dot4_q;
    end
  end

  assign sq_w[0].n = gcd_pkg::sq_t'(rad_q);
  assign sq_w[0].r = '0;
  assign sq_w[0].d = dot5_q;

  for (genvar k = 0; k < gcd_pkg::SqSteps; k++) begin : g_sqrt
    gcd_isqrt_cell #(.STEP(k)) u_cell (
      .clk_i, .en_i(adv), .cell_i(sq_w[k]), .cell_o(sq_w[k+1])
    );
  end

  assign d_fin = sq_w[gcd_pkg::SqSteps].d;
  assign d_abs = d_fin[TW-1] ? -d_fin : d_fin;
  assign acs_w[0].x = d_abs;
  assign acs_w[0].y = TW'(sq_w[gcd_pkg::SqSteps].r);
  assign acs_w[0].z = '0;
  assign acs_w[0].flag = d_fin[TW-1];

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_acos
    gcd_cordic_cell #(.STAGE(i), .VECTORING(1'b1)) u_cell (
      .clk_i, .en_i(adv), .cell_i(acs_w[i]), .cell_o(acs_w[i+1])
    );
  end

  // negative cosine mirrors the angle about pi/2, then clamp to [0, pi]
  always_comb begin
    if (acs_w[TRIG_STEPS].flag) ang_raw = gcd_pkg::PiQ30 - 35'(acs_w[TRIG_STEPS].z);
    else ang_raw = 35'(acs_w[TRIG_STEPS].z);
    if (ang_raw < 0) ang_raw = '0;
    else if (ang_raw > gcd_pkg::PiQ30) ang_raw = gcd_pkg::PiQ30;
    prod_rnd = (prod_q + (56'd1 << 29)) >> 30;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q  <= ang_raw[31:0];
      prod_q <= 56'(ang_q) * 56'(radius_q);
      dist_q <= prod_rnd[gcd_pkg::DistW-1:0];
    end
  end

  assign out_valid_o = vld_q[Lat-1];
  assign distance_m_o = dist_q;

endmodule

[rtl/gcd_checker.sv]
`timescale 1ns / 1ps

module gcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [25:0] distance_m_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(distance_m_o))
    else $error("stalled result changed");

  // input backpressure only while a result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output hold");

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .distance_m_o(distance_m_o)
);
